@@ rtl/apm_pkg.sv @@
// Shared types, constants and the segment decoder for the averaging panel meter.
// No dependencies; used by averaging_panel_meter.
package apm_pkg;

    localparam int SAMPLE_W        = 10;  // ADC sample field
    localparam int CNT_W           = 8;   // sample count and count registers
    localparam int SUM_W           = 18;  // running sum of up to 255 samples
    localparam int READ_W          = 10;  // reading in tenths
    localparam int SEG_W           = 7;   // gfedcba
    localparam int CFG_IDX_W       = 1;
    localparam int ADC_BITS_DEFAULT = 10;

    localparam logic [15:0]       SCALE_VOLT_Q16  = 16'd18626;  // 0.284207
    localparam logic [15:0]       SCALE_CURR_Q16  = 16'd17297;  // 0.263936
    localparam int                Q16_SHIFT       = 16;
    localparam logic [READ_W-1:0] READING_MAX     = 10'd999;
    localparam logic [CNT_W-1:0]  SAMPLES_RESET   = 8'd64;

    // n / 100 = (n * 41) >> 12 for n < 1000; r / 10 = (r * 205) >> 11 for r < 100
    localparam logic [15:0] HUND_RECIP = 16'd41;
    localparam logic [14:0] TEN_RECIP  = 15'd205;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_VOLTAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_CURRENT = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    localparam logic MODE_VOLTAGE = 1'b0;
    localparam logic MODE_CURRENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_MULT,
        ST_SCALE,
        ST_DIGIT_H,
        ST_DIGIT_TU
    } state_t;

    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/averaging_panel_meter.sv @@
// Averaging panel meter: sample accumulation, iterative mean, scaling and
// seven-segment encoding. Depends on apm_pkg.
//
// Usage:
//   Input words carry either an ADC sample (s_opcode = sample) or a button
//   level (s_opcode = button). A released-to-pressed edge of the button flips
//   between voltage and current mode and drops the partial sum.
//   Samples are summed until the count register of the current mode is
//   reached; that word then produces one output word with three segment
//   codes, the reading in tenths (0..999) and the mode.
//   Words that do not close a block are accepted without leaving idle. A
//   closing sample is accepted, then runs through the restoring divider
//   (one quotient bit per cycle through one subtractor), then multiply with
//   rounding, saturate, and two digit-split steps before the result is loaded.
//   s_ready is high only while the sequencer is idle.
//   Results sit in an output register; if the receiver stalls, the block
//   keeps taking words that do not close a block and holds the next result
//   in its last step until the register frees up.
//   Configuration (cfg_wr_en, cfg_index, cfg_wr_data) writes take effect at
//   once. Reset (aresetn low, synchronous) clears the sum, count and output
//   valid, selects voltage mode, marks the button released and sets both
//   count registers to 64.
module averaging_panel_meter #(
    parameter int ADC_BITS = apm_pkg::ADC_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [apm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apm_pkg::CNT_W-1:0]         cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [apm_pkg::SAMPLE_W-1:0]      s_sample,
    input  logic                              s_button_level,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [apm_pkg::SEG_W-1:0]         m_seg_hundreds,
    output logic [apm_pkg::SEG_W-1:0]         m_seg_tens,
    output logic [apm_pkg::SEG_W-1:0]         m_seg_units,
    output logic [apm_pkg::READ_W-1:0]        m_reading,
    output logic                              m_meter_mode
);

    localparam int SAMPLE_W = apm_pkg::SAMPLE_W;
    localparam int CNT_W    = apm_pkg::CNT_W;
    localparam int SUM_W    = apm_pkg::SUM_W;
    localparam int READ_W   = apm_pkg::READ_W;
    localparam int SEG_W    = apm_pkg::SEG_W;
    localparam int ITER_W   = $clog2(SUM_W);
    localparam int MAG_W    = (ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam int PROD_W   = MAG_W + 16;
    localparam logic [MAG_W-1:0]  MID       = MAG_W'(1) << (ADC_BITS - 1);
    localparam logic [PROD_W-1:0] ROUND_Q16 = PROD_W'(1) << (apm_pkg::Q16_SHIFT - 1);

    apm_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]   samples_voltage_reg, samples_current_reg;
    logic               mode_reg, mode_next;
    logic               button_prev_reg, button_prev_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic [SUM_W-1:0]   dq_reg, dq_next;      // dividend, shifts into quotient
    logic [CNT_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [READ_W-1:0]  n_reg, n_next;
    logic [3:0]         hund_reg, hund_next;
    logic [6:0]         rem100_reg, rem100_next;

    logic               m_valid_reg, m_valid_next;
    logic [SEG_W-1:0]   seg_h_reg, seg_h_next;
    logic [SEG_W-1:0]   seg_t_reg, seg_t_next;
    logic [SEG_W-1:0]   seg_u_reg, seg_u_next;
    logic [READ_W-1:0]  reading_reg, reading_next;
    logic               mode_out_reg, mode_out_next;

    // control
    logic               s_fire;
    logic               out_load;
    logic               div_last;

    // datapath terms
    logic [SAMPLE_W-1:0] sample_masked;
    logic [CNT_W-1:0]    target;
    logic [CNT_W-1:0]    count_inc;
    logic [SUM_W-1:0]    sum_inc;
    logic                blk_done;
    logic [CNT_W:0]      rem_shift;
    logic [CNT_W:0]      rem_sub;
    logic                div_ge;
    logic [MAG_W-1:0]    mean_ext;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    mul_op;
    logic [15:0]         mul_scale;
    logic [MAG_W-1:0]    scaled;
    logic [15:0]         hund_prod;
    logic [3:0]          hund_digit;
    logic [READ_W-1:0]   hund_part;
    logic [14:0]         ten_prod;
    logic [3:0]          ten_digit;
    logic [6:0]          ten_part;
    logic [3:0]          unit_digit;

    assign s_fire   = s_valid & s_ready;
    assign div_last = (iter_reg == ITER_W'(SUM_W - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            apm_pkg::ST_IDLE: begin
                if (s_valid && s_opcode == apm_pkg::OP_SAMPLE && blk_done) begin
                    state_next = apm_pkg::ST_DIVIDE;
                end
            end
            apm_pkg::ST_DIVIDE: begin
                if (div_last) begin
                    state_next = apm_pkg::ST_MULT;
                end
            end
            apm_pkg::ST_MULT:    state_next = apm_pkg::ST_SCALE;
            apm_pkg::ST_SCALE:   state_next = apm_pkg::ST_DIGIT_H;
            apm_pkg::ST_DIGIT_H: state_next = apm_pkg::ST_DIGIT_TU;
            apm_pkg::ST_DIGIT_TU: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = apm_pkg::ST_IDLE;
                end
            end
            default: state_next = apm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            apm_pkg::ST_IDLE:     s_ready  = 1'b1;
            apm_pkg::ST_DIGIT_TU: out_load = !m_valid_reg || m_ready;
            default: begin
                s_ready  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // shared arithmetic terms
    always_comb begin
        for (int i = 0; i < SAMPLE_W; i++) begin
            sample_masked[i] = (i < ADC_BITS) ? s_sample[i] : 1'b0;
        end
        target    = (mode_reg == apm_pkg::MODE_VOLTAGE) ? samples_voltage_reg
                                                        : samples_current_reg;
        if (target == '0) begin
            target = CNT_W'(1);
        end
        count_inc = count_reg + CNT_W'(1);
        sum_inc   = sum_reg + SUM_W'(sample_masked);
        blk_done  = (count_inc >= target);

        rem_shift = {rem_reg, dq_reg[SUM_W-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        div_ge    = (rem_shift >= {1'b0, div_reg});

        // quotient never exceeds the largest sample
        mean_ext  = MAG_W'(dq_reg[SAMPLE_W-1:0]);
        mag       = (mean_ext >= MID) ? (mean_ext - MID) : (MID - mean_ext);
        mul_op    = (mode_reg == apm_pkg::MODE_VOLTAGE) ? mean_ext : mag;
        mul_scale = (mode_reg == apm_pkg::MODE_VOLTAGE) ? apm_pkg::SCALE_VOLT_Q16
                                                        : apm_pkg::SCALE_CURR_Q16;

        scaled    = prod_reg[PROD_W-1:apm_pkg::Q16_SHIFT];

        hund_prod  = 16'(n_reg) * apm_pkg::HUND_RECIP;
        hund_digit = hund_prod[15:12];
        hund_part  = READ_W'(hund_digit) * READ_W'(100);

        ten_prod   = 15'(rem100_reg) * apm_pkg::TEN_RECIP;
        ten_digit  = ten_prod[14:11];
        ten_part   = 7'(ten_digit) * 7'd10;
        unit_digit = 4'(rem100_reg - ten_part);
    end

    // register next values
    always_comb begin
        mode_next        = mode_reg;
        button_prev_next = button_prev_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        dq_next          = dq_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        iter_next        = iter_reg;
        prod_next        = prod_reg;
        n_next           = n_reg;
        hund_next        = hund_reg;
        rem100_next      = rem100_reg;
        m_valid_next     = m_valid_reg & ~m_ready;
        seg_h_next       = seg_h_reg;
        seg_t_next       = seg_t_reg;
        seg_u_next       = seg_u_reg;
        reading_next     = reading_reg;
        mode_out_next    = mode_out_reg;

        case (state_reg)
            apm_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == apm_pkg::OP_BUTTON) begin
                        button_prev_next = s_button_level;
                        if (button_prev_reg && !s_button_level) begin
                            mode_next  = ~mode_reg;
                            sum_next   = '0;
                            count_next = '0;
                        end
                    end else if (blk_done) begin
                        dq_next    = sum_inc;
                        div_next   = count_inc;
                        rem_next   = '0;
                        iter_next  = '0;
                        sum_next   = '0;
                        count_next = '0;
                    end else begin
                        sum_next   = sum_inc;
                        count_next = count_inc;
                    end
                end
            end
            apm_pkg::ST_DIVIDE: begin
                rem_next  = div_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                dq_next   = {dq_reg[SUM_W-2:0], div_ge};
                iter_next = iter_reg + ITER_W'(1);
            end
            apm_pkg::ST_MULT: begin
                prod_next = PROD_W'(mul_op) * PROD_W'(mul_scale) + ROUND_Q16;
            end
            apm_pkg::ST_SCALE: begin
                n_next = (scaled > MAG_W'(apm_pkg::READING_MAX)) ? apm_pkg::READING_MAX
                                                                 : scaled[READ_W-1:0];
            end
            apm_pkg::ST_DIGIT_H: begin
                hund_next   = hund_digit;
                rem100_next = 7'(n_reg - hund_part);
            end
            apm_pkg::ST_DIGIT_TU: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    seg_h_next    = apm_pkg::seg_code(hund_reg);
                    seg_t_next    = apm_pkg::seg_code(ten_digit);
                    seg_u_next    = apm_pkg::seg_code(unit_digit);
                    reading_next  = n_reg;
                    mode_out_next = mode_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg & ~m_ready;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= apm_pkg::ST_IDLE;
            samples_voltage_reg <= apm_pkg::SAMPLES_RESET;
            samples_current_reg <= apm_pkg::SAMPLES_RESET;
            mode_reg            <= apm_pkg::MODE_VOLTAGE;
            button_prev_reg     <= 1'b1;
            sum_reg             <= '0;
            count_reg           <= '0;
            iter_reg            <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            button_prev_reg <= button_prev_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            iter_reg        <= iter_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    apm_pkg::CFG_SAMPLES_VOLTAGE: samples_voltage_reg <= cfg_wr_data;
                    apm_pkg::CFG_SAMPLES_CURRENT: samples_current_reg <= cfg_wr_data;
                    default:                      samples_voltage_reg <= samples_voltage_reg;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        dq_reg       <= dq_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        n_reg        <= n_next;
        hund_reg     <= hund_next;
        rem100_reg   <= rem100_next;
        seg_h_reg    <= seg_h_next;
        seg_t_reg    <= seg_t_next;
        seg_u_reg    <= seg_u_next;
        reading_reg  <= reading_next;
        mode_out_reg <= mode_out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_seg_hundreds = seg_h_reg;
    assign m_seg_tens     = seg_t_reg;
    assign m_seg_units    = seg_u_reg;
    assign m_reading      = reading_reg;
    assign m_meter_mode   = mode_out_reg;

endmodule

@@ tb/averaging_panel_meter_tb.sv @@
// Self-checking testbench for averaging_panel_meter: directed table, then random phases.
// Depends on apm_pkg and the averaging_panel_meter RTL; needs no other files.
module averaging_panel_meter_tb;

    typedef struct packed {
        logic [apm_pkg::SEG_W-1:0]  hund;
        logic [apm_pkg::SEG_W-1:0]  tens;
        logic [apm_pkg::SEG_W-1:0]  units;
        logic [apm_pkg::READ_W-1:0] reading;
        logic                       mode;
    } display_t;

    typedef struct packed {
        bit                            is_cfg;
        logic [apm_pkg::CFG_IDX_W-1:0] idx;
        logic [apm_pkg::CNT_W-1:0]     val;
        logic                          op;
        logic [apm_pkg::SAMPLE_W-1:0]  smp;
        logic                          btn;
        bit                            known;
        display_t                      disp;
    } stim_row_t;

    localparam int unsigned VOLT_GAIN = 18626;
    localparam int unsigned CURR_GAIN = 17297;
    localparam int unsigned ADC_MID   = 1 << (apm_pkg::SAMPLE_W - 1);
    localparam int unsigned CAP       = 999;
    localparam int          SEG_W     = apm_pkg::SEG_W;
    // digit 9 in the top slice, digit 0 in the bottom one
    localparam logic [10*SEG_W-1:0] SEG_ROM = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                               7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    localparam display_t SHOW_0_V   = {7'h3F, 7'h3F, 7'h3F, 10'd0, apm_pkg::MODE_VOLTAGE};
    localparam display_t SHOW_291_V = {7'h5B, 7'h6F, 7'h06, 10'd291, apm_pkg::MODE_VOLTAGE};
    localparam display_t SHOW_0_C   = {7'h3F, 7'h3F, 7'h3F, 10'd0, apm_pkg::MODE_CURRENT};
    localparam display_t SHOW_135_C = {7'h06, 7'h4F, 7'h6D, 10'd135, apm_pkg::MODE_CURRENT};

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_wr_en      = 1'b0;
    logic [apm_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
    logic [apm_pkg::CNT_W-1:0]     cfg_wr_data    = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic                          s_opcode       = apm_pkg::OP_SAMPLE;
    logic [apm_pkg::SAMPLE_W-1:0]  s_sample       = '0;
    logic                          s_button_level = 1'b1;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [apm_pkg::SEG_W-1:0]     m_seg_hundreds;
    logic [apm_pkg::SEG_W-1:0]     m_seg_tens;
    logic [apm_pkg::SEG_W-1:0]     m_seg_units;
    logic [apm_pkg::READ_W-1:0]    m_reading;
    logic                          m_meter_mode;

    // mirror of the meter state
    logic        mode_q     = apm_pkg::MODE_VOLTAGE;
    logic        btn_prev_q = 1'b1;
    int unsigned acc_sum    = 0;
    int unsigned acc_count  = 0;
    int unsigned cnt_volt   = 32'(apm_pkg::SAMPLES_RESET);
    int unsigned cnt_curr   = 32'(apm_pkg::SAMPLES_RESET);

    display_t    pending_displays[$];
    stim_row_t   dir_rows[$];
    int          fail_count   = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    bit          rx_long_hold = 1'b0;
    int          hold_left    = 0;
    int          run_left     = 50;

    averaging_panel_meter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_sample       (s_sample),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_seg_hundreds (m_seg_hundreds),
        .m_seg_tens     (m_seg_tens),
        .m_seg_units    (m_seg_units),
        .m_reading      (m_reading),
        .m_meter_mode   (m_meter_mode)
    );

    always #2 aclk = ~aclk;

    // Advance the meter state by one word; done is set when the word closes a block.
    task automatic meter_update(input logic op, input logic [apm_pkg::SAMPLE_W-1:0] smp,
                                input logic btn, output bit done, output display_t disp);
        int unsigned goal;
        int unsigned mean;
        int unsigned mag;
        int unsigned val;
        done = 1'b0;
        disp = '0;
        if (op == apm_pkg::OP_BUTTON) begin
            if (btn_prev_q && !btn) begin
                mode_q    = ~mode_q;
                acc_sum   = 0;
                acc_count = 0;
            end
            btn_prev_q = btn;
        end else begin
            acc_sum   += 32'(smp);
            acc_count += 1;
            goal = (mode_q == apm_pkg::MODE_VOLTAGE) ? cnt_volt : cnt_curr;
            if (goal == 0) goal = 1;
            if (acc_count >= goal) begin
                mean = acc_sum / acc_count;
                if (mode_q == apm_pkg::MODE_VOLTAGE) begin
                    val = (mean * VOLT_GAIN + 32768) >> 16;
                end else begin
                    mag = (mean >= ADC_MID) ? mean - ADC_MID : ADC_MID - mean;
                    val = (mag * CURR_GAIN + 32768) >> 16;
                end
                if (val > CAP) val = CAP;
                disp.hund    = SEG_ROM[(val / 100) % 10 * SEG_W +: SEG_W];
                disp.tens    = SEG_ROM[(val / 10) % 10 * SEG_W +: SEG_W];
                disp.units   = SEG_ROM[val % 10 * SEG_W +: SEG_W];
                disp.reading = val[apm_pkg::READ_W-1:0];
                disp.mode    = mode_q;
                acc_sum   = 0;
                acc_count = 0;
                done      = 1'b1;
            end
        end
    endtask

    // Drop valid and wait for every expected display word, then keep valid low for the extra wait set by n.
    task automatic settle(input int n);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_displays.size() != 0) @(posedge aclk);
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [apm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [apm_pkg::CNT_W-1:0] val);
        settle(30);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == apm_pkg::CFG_SAMPLES_VOLTAGE) cnt_volt = 32'(val);
        else cnt_curr = 32'(val);
    endtask

    // Offer one word; valid stays up on return so the next word can follow at once.
    task automatic send_word(input logic op, input logic [apm_pkg::SAMPLE_W-1:0] smp,
                             input logic btn, input bit known, input display_t known_disp);
        bit       done;
        display_t disp;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_sample       <= smp;
        s_button_level <= btn;
        do @(posedge aclk); while (!s_ready);
        meter_update(op, smp, btn, done, disp);
        if (known) pending_displays.push_back(known_disp);
        else if (done) pending_displays.push_back(disp);
    endtask

    function automatic stim_row_t row_cfg(input logic [apm_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [apm_pkg::CNT_W-1:0] val);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic stim_row_t row_word(input logic op,
                                           input logic [apm_pkg::SAMPLE_W-1:0] smp,
                                           input logic btn, input bit known,
                                           input display_t disp);
        stim_row_t r;
        r       = '0;
        r.op    = op;
        r.smp   = smp;
        r.btn   = btn;
        r.known = known;
        r.disp  = disp;
        return r;
    endfunction

    // Receiver: random stalls, plus long hold-offs while rx_long_hold is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            run_left  <= 50;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_long_hold && run_left == 0) begin
            m_ready   <= 1'b0;
            hold_left <= 300;
            run_left  <= 50;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
            if (rx_long_hold) run_left <= run_left - 1;
        end
    end

    always @(posedge aclk) begin : check_words
        display_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_displays.size() == 0) begin
                $error("unexpected output word: reading %0d", m_reading);
                fail_count++;
            end else begin
                want = pending_displays.pop_front();
                if (m_seg_hundreds !== want.hund) begin
                    $error("seg_hundreds: expected %h, got %h", want.hund, m_seg_hundreds);
                    fail_count++;
                end
                if (m_seg_tens !== want.tens) begin
                    $error("seg_tens: expected %h, got %h", want.tens, m_seg_tens);
                    fail_count++;
                end
                if (m_seg_units !== want.units) begin
                    $error("seg_units: expected %h, got %h", want.units, m_seg_units);
                    fail_count++;
                end
                if (m_reading !== want.reading) begin
                    $error("reading: expected %0d, got %0d", want.reading, m_reading);
                    fail_count++;
                end
                if (m_meter_mode !== want.mode) begin
                    $error("meter_mode: expected %0d, got %0d", want.mode, m_meter_mode);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int                           ph_tx[6];
        int                           ph_rx[6];
        int                           ph_btn[6];
        int                           ph_volt[6];
        int                           ph_curr[6];
        int                           ph_items[6];
        logic                         op;
        logic [apm_pkg::SAMPLE_W-1:0] smp;
        stim_row_t                    r;

        ph_tx    = '{0, 88, 0, 8, 0, 8};
        ph_rx    = '{0, 0, 88, 8, 0, 8};
        ph_btn   = '{5, 8, 5, 8, 0, 5};
        ph_volt  = '{1, 3, 4, 2, 255, 0};
        ph_curr  = '{1, 2, 7, 5, 255, 16};
        ph_items = '{150, 250, 250, 350, 400, 350};

        // voltage mode, one sample per reading
        dir_rows.push_back(row_cfg(apm_pkg::CFG_SAMPLES_VOLTAGE, 8'd1));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd0, 1'b1, 1'b1, SHOW_0_V));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd1023, 1'b1, 1'b1, SHOW_291_V));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'h2AA, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'h155, 1'b1, 1'b0, '0));
        // released level is no edge; press flips to current mode
        dir_rows.push_back(row_word(apm_pkg::OP_BUTTON, 10'd0, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_BUTTON, 10'd0, 1'b0, 1'b0, '0));
        dir_rows.push_back(row_cfg(apm_pkg::CFG_SAMPLES_CURRENT, 8'd1));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd512, 1'b1, 1'b1, SHOW_0_C));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd0, 1'b1, 1'b1, SHOW_135_C));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd1023, 1'b1, 1'b0, '0));
        // held press, release, then a fresh press back to voltage
        dir_rows.push_back(row_word(apm_pkg::OP_BUTTON, 10'd0, 1'b0, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_BUTTON, 10'd0, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_BUTTON, 10'd0, 1'b0, 1'b0, '0));
        // zero count acts as one
        dir_rows.push_back(row_cfg(apm_pkg::CFG_SAMPLES_VOLTAGE, 8'd0));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd700, 1'b1, 1'b0, '0));
        // count lowered under the partial block: next sample closes it
        dir_rows.push_back(row_cfg(apm_pkg::CFG_SAMPLES_VOLTAGE, 8'd64));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd1023, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd1, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd511, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_cfg(apm_pkg::CFG_SAMPLES_VOLTAGE, 8'd2));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd300, 1'b1, 1'b0, '0));
        // press mid-block drops the partial sum
        dir_rows.push_back(row_cfg(apm_pkg::CFG_SAMPLES_VOLTAGE, 8'd5));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd1, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd2, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_BUTTON, 10'd0, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_BUTTON, 10'd0, 1'b0, 1'b0, '0));
        dir_rows.push_back(row_cfg(apm_pkg::CFG_SAMPLES_CURRENT, 8'd2));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd100, 1'b1, 1'b0, '0));
        dir_rows.push_back(row_word(apm_pkg::OP_SAMPLE, 10'd900, 1'b1, 1'b0, '0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.is_cfg) write_reg(r.idx, r.val);
            else send_word(r.op, r.smp, r.btn, r.known, r.disp);
        end

        for (int p = 0; p < 6; p++) begin
            write_reg(apm_pkg::CFG_SAMPLES_VOLTAGE, apm_pkg::CNT_W'(ph_volt[p]));
            write_reg(apm_pkg::CFG_SAMPLES_CURRENT, apm_pkg::CNT_W'(ph_curr[p]));
            tx_idle_pct  = ph_tx[p];
            rx_stall_pct = ph_rx[p];
            rx_long_hold = (p == 0);
            for (int i = 0; i < ph_items[p]; i++) begin
                // sender waits out every pending word once
                if (p == 0 && i == ph_items[p] / 2) settle(0);
                op = ($urandom_range(99) < ph_btn[p]) ? apm_pkg::OP_BUTTON
                                                      : apm_pkg::OP_SAMPLE;
                case ($urandom_range(7))
                    0:       smp = '1;
                    1:       smp = '0;
                    default: smp = apm_pkg::SAMPLE_W'($urandom_range(1023));
                endcase
                send_word(op, smp, 1'($urandom_range(1)), 1'b0, '0);
            end
        end
        rx_long_hold = 1'b0;

        settle(30);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
